// ===== rtl/spk_pkg.sv =====
`timescale 1ns / 1ps

package spk_pkg;

    // Word size of the cipher and number of rounds.
    localparam int WORD_W = 64;
    localparam int ROUNDS = 32;
    localparam int CNT_W  = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    // Configuration port: two 64-bit key registers at byte addresses 0 and 8.
    localparam int APB_AW = 4;
    localparam int APB_DW = 64;
    localparam int REG_SEL_BIT = 3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_cnt RND_LAST = CNT_W'(ROUNDS - 1);

    // Operation codes carried by the op field.
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // Register select codes (address bit 3).
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // The two halves of a block: x is the high word and y the low word.
    typedef struct packed {
        t_word x;
        t_word y;
    } t_pair;

    // One forward round, also used by the key schedule.
    function automatic t_pair spk_enc_round(t_word x, t_word y, t_word k);
        t_word xr;
        t_word xn;
        t_pair res;
        xr    = {x[7:0], x[WORD_W-1:8]};
        xn    = (xr + y) ^ k;
        res.x = xn;
        res.y = {y[WORD_W-4:0], y[WORD_W-1:WORD_W-3]} ^ xn;
        return res;
    endfunction

    // One inverse round.
    function automatic t_pair spk_dec_round(t_word x, t_word y, t_word k);
        t_word yt;
        t_word yn;
        t_word xt;
        t_pair res;
        yt    = y ^ x;
        yn    = {yt[2:0], yt[WORD_W-1:3]};
        xt    = (x ^ k) - yn;
        res.x = {xt[WORD_W-9:0], xt[WORD_W-1:WORD_W-8]};
        res.y = yn;
        return res;
    endfunction

endpackage

// ===== rtl/spk_blk_if.sv =====
`timescale 1ns / 1ps

// Input channel: one block and the operation to apply to it.
interface spk_blk_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [63:0] block_low;
    logic [63:0] block_high;

    modport source (output valid, output op, output block_low, output block_high,
                    input ready);
    modport sink (input valid, input op, input block_low, input block_high,
                  output ready);
endinterface

// ===== rtl/spk_res_if.sv =====
`timescale 1ns / 1ps

// Output channel: one processed block.
interface spk_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;

    modport source (output valid, output result_low, output result_high, input ready);
    modport sink (input valid, input result_low, input result_high, output ready);
endinterface

// ===== rtl/spk_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module spk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/speck_128_128_block_cipher_top.sv =====
`timescale 1ns / 1ps

// Speck 128/128 cipher core. Write the key through the APB port (low word at
// byte address 0, high word at 8); after reset and after every key write the
// core expands the 32 round keys into its round key RAM, and takes no item
// during that time. An item carries a block as a low and a high word and an op
// bit (0 encrypt, 1 decrypt). The core runs one round per cycle, reading one
// round key from the RAM each cycle, with the last round held until the output
// register is free; a new item is taken in the cycle the previous result is
// loaded into the output register. Items are processed one at a time; a result
// waits in the output register until it is taken.
module speck_128_128_block_cipher_top import spk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spk_blk_if.sink           i_blk,
    spk_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_EXPAND = 3'b001,
        ST_IDLE   = 3'b010,
        ST_RUN    = 3'b100
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt;
    t_word  r_key_low, n_key_low;
    t_word  r_key_high, n_key_high;
    t_word  r_ka, n_ka;
    t_word  r_kb, n_kb;
    t_word  r_x, n_x;
    t_word  r_y, n_y;
    logic   r_op, n_op;
    logic   r_out_valid, n_out_valid;
    t_word  r_res_low, n_res_low;
    t_word  r_res_high, n_res_high;

    logic   in_ready;
    logic   blk_take;
    logic   out_free;
    logic   cfg_wr;
    logic   ram_we;
    t_cnt   ram_raddr;
    t_word  round_key;
    t_pair  cipher_next;
    t_pair  sched_next;

    // Round key storage.
    spk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROUNDS)
    ) u_rk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt),
        .i_wdata (r_ka),
        .i_raddr (ram_raddr),
        .o_rdata (round_key)
    );

    // Round datapaths.
    assign cipher_next = (r_op == OP_DEC) ? spk_dec_round(r_x, r_y, round_key)
                                          : spk_enc_round(r_x, r_y, round_key);
    assign sched_next  = spk_enc_round(r_kb, r_ka, {{(WORD_W-CNT_W){1'b0}}, r_cnt});

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !r_out_valid || o_res.ready;
    assign blk_take = i_blk.valid && in_ready;

    // Control and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_key_low   = r_key_low;
        n_key_high  = r_key_high;
        n_ka        = r_ka;
        n_kb        = r_kb;
        n_x         = r_x;
        n_y         = r_y;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        n_res_low   = r_res_low;
        n_res_high  = r_res_high;
        in_ready    = 1'b0;
        ram_we      = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_EXPAND: begin
                // Store the current round key and step the schedule.
                ram_we = 1'b1;
                n_ka   = sched_next.y;
                n_kb   = sched_next.x;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == RND_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_RUN: begin
                if (r_cnt != RND_LAST) begin
                    n_x   = cipher_next.x;
                    n_y   = cipher_next.y;
                    n_cnt = r_cnt + 1'b1;
                end else if (out_free) begin
                    // Last round goes straight into the output register.
                    n_res_high  = cipher_next.x;
                    n_res_low   = cipher_next.y;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    in_ready    = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A new item starts at round zero.
        if (blk_take) begin
            n_x     = i_blk.block_high;
            n_y     = i_blk.block_low;
            n_op    = i_blk.op;
            n_cnt   = '0;
            n_state = ST_RUN;
        end

        // A key write restarts the key expansion.
        if (cfg_wr) begin
            unique case (paddr[REG_SEL_BIT])
                REG_KEY_LOW:  n_key_low  = pwdata;
                REG_KEY_HIGH: n_key_high = pwdata;
                default:      n_key_low  = r_key_low;
            endcase
            n_ka    = n_key_low;
            n_kb    = n_key_high;
            n_cnt   = '0;
            n_state = ST_EXPAND;
        end
    end

    // Read address runs one round ahead; decryption walks the keys backward.
    assign ram_raddr = (n_op == OP_DEC) ? (RND_LAST - n_cnt) : n_cnt;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_EXPAND;
            r_cnt       <= '0;
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_ka        <= '0;
            r_kb        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_key_low   <= n_key_low;
            r_key_high  <= n_key_high;
            r_ka        <= n_ka;
            r_kb        <= n_kb;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_y        <= n_y;
        r_op       <= n_op;
        r_res_low  <= n_res_low;
        r_res_high <= n_res_high;
    end

    // Outputs.
    assign i_blk.ready       = in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.result_low  = r_res_low;
    assign o_res.result_high = r_res_high;
    assign pready            = 1'b1;
    assign prdata            = (paddr[REG_SEL_BIT] == REG_KEY_HIGH) ? r_key_high : r_key_low;

endmodule
